// ===== hdl/port_knock_sequence_filter_assert.svh =====
// ----------------------------------------------------------------------------
// Port knock sequence filter assertion macros
// Concurrent check macros; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef PORT_KNOCK_SEQUENCE_FILTER_ASSERT_SVH
`define PORT_KNOCK_SEQUENCE_FILTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PSF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PSF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define PSF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define PSF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/psf_pkg.sv =====
// ----------------------------------------------------------------------------
// Port knock sequence filter package
// Shared types, register codes, reset values and helpers.
// ----------------------------------------------------------------------------
package psf_pkg;

   localparam int SLOTS_DEFAULT = 16;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [15:0] KNOCK_FIRST_RST    = 16'd1500;
   localparam logic [15:0] KNOCK_SECOND_RST   = 16'd2000;
   localparam logic [15:0] KNOCK_THIRD_RST    = 16'd2500;
   localparam logic [1:0]  KNOCK_LENGTH_RST   = 2'd3;
   localparam logic [15:0] GUARDED_PORT_RST   = 16'd0;
   localparam logic [1:0]  GUARDED_COUNT_RST  = 2'd0;

   localparam logic [1:0] L3_IPV4 = 2'd1;
   localparam logic [1:0] L3_IPV6 = 2'd2;

   typedef enum logic [2:0] {
      REG_KNOCK_FIRST,
      REG_KNOCK_SECOND,
      REG_KNOCK_THIRD,
      REG_KNOCK_LENGTH,
      REG_GUARDED_PORT_A,
      REG_GUARDED_PORT_B,
      REG_GUARDED_COUNT
   } reg_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [15:0] knock_first;
      logic [15:0] knock_second;
      logic [15:0] knock_third;
      logic [1:0]  knock_length;
      logic [15:0] guarded_port_a;
      logic [15:0] guarded_port_b;
      logic [1:0]  guarded_count;
   } cfg_type;

   typedef struct packed {
      logic        v6;
      logic [63:0] hi;
      logic [63:0] lo;
   } key_type;

   typedef struct packed {
      logic       hit;
      logic       free;
      logic [1:0] prog;
   } carry_type;

   typedef struct packed {
      logic       en;
      logic       alloc;
      logic       valid_new;
      logic [1:0] prog_new;
   } cmd_type;

   function automatic logic [15:0] knock_at(cfg_type cfg, logic [1:0] p);
      logic [15:0] port;
      case (p)
         2'd0:    port = cfg.knock_first;
         2'd1:    port = cfg.knock_second;
         default: port = cfg.knock_third;
      endcase
      return port;
   endfunction

endpackage

// ===== hdl/psf_cell.sv =====
// ----------------------------------------------------------------------------
// Sender slot cell
// Holds one tracked sender, matches the scan word as it passes and applies
// the update command when selected.
// ----------------------------------------------------------------------------
module psf_cell import psf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      tok_prev,
   input  carry_type carry_prev,
   input  key_type   key,
   input  cmd_type   cmd,
   output logic      tok_next,
   output carry_type carry_next
);

   logic        valid_ff, valid_in;
   logic        v6_ff;
   logic [63:0] hi_ff;
   logic [63:0] lo_ff;
   logic [1:0]  prog_ff;
   logic        hit_ff, hit_in;
   logic        first_ff, first_in;
   logic        tok_ff;
   carry_type   carry_ff, carry_in;
   logic        sel;

   always_comb begin
      hit_in   = valid_ff && (v6_ff == key.v6) && (hi_ff == key.hi) && (lo_ff == key.lo);
      first_in = !valid_ff && !carry_prev.free;
      carry_in.hit  = carry_prev.hit || hit_in;
      carry_in.free = carry_prev.free || !valid_ff;
      carry_in.prog = hit_in ? prog_ff : carry_prev.prog;
      sel      = cmd.en && (cmd.alloc ? first_ff : hit_ff);
      valid_in = sel ? cmd.valid_new : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_prev) begin
         hit_ff   <= hit_in;
         first_ff <= first_in;
         carry_ff <= carry_in;
      end
      if (sel) begin
         v6_ff   <= key.v6;
         hi_ff   <= key.hi;
         lo_ff   <= key.lo;
         prog_ff <= cmd.prog_new;
      end
   end

   assign tok_next   = tok_ff;
   assign carry_next = carry_ff;

endmodule

// ===== hdl/psf_csr.sv =====
// ----------------------------------------------------------------------------
// Port knock sequence filter register file
// APB-style access to the knock and hidden port settings.
// ----------------------------------------------------------------------------
module psf_csr import psf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr;

   always_comb begin
      idx    = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
      wr     = psel && penable && pwrite;
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_KNOCK_FIRST:    cfg_in.knock_first    = pwdata[15:0];
            REG_KNOCK_SECOND:   cfg_in.knock_second   = pwdata[15:0];
            REG_KNOCK_THIRD:    cfg_in.knock_third    = pwdata[15:0];
            REG_KNOCK_LENGTH:   cfg_in.knock_length   = pwdata[1:0];
            REG_GUARDED_PORT_A: cfg_in.guarded_port_a = pwdata[15:0];
            REG_GUARDED_PORT_B: cfg_in.guarded_port_b = pwdata[15:0];
            REG_GUARDED_COUNT:  cfg_in.guarded_count  = pwdata[1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_KNOCK_FIRST:    prdata = {16'd0, cfg_ff.knock_first};
         REG_KNOCK_SECOND:   prdata = {16'd0, cfg_ff.knock_second};
         REG_KNOCK_THIRD:    prdata = {16'd0, cfg_ff.knock_third};
         REG_KNOCK_LENGTH:   prdata = {30'd0, cfg_ff.knock_length};
         REG_GUARDED_PORT_A: prdata = {16'd0, cfg_ff.guarded_port_a};
         REG_GUARDED_PORT_B: prdata = {16'd0, cfg_ff.guarded_port_b};
         REG_GUARDED_COUNT:  prdata = {30'd0, cfg_ff.guarded_count};
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.knock_first    <= KNOCK_FIRST_RST;
         cfg_ff.knock_second   <= KNOCK_SECOND_RST;
         cfg_ff.knock_third    <= KNOCK_THIRD_RST;
         cfg_ff.knock_length   <= KNOCK_LENGTH_RST;
         cfg_ff.guarded_port_a <= GUARDED_PORT_RST;
         cfg_ff.guarded_port_b <= GUARDED_PORT_RST;
         cfg_ff.guarded_count  <= GUARDED_COUNT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

// ===== hdl/port_knock_sequence_filter.sv =====
// ----------------------------------------------------------------------------
// Port knock sequence filter
// Judges one packet descriptor per command: start with the req_ fields while
// busy is low. Every command yields one result word, shown for one cycle
// with rsp_strobe; the receiver cannot stall it.
// Words that need no sender lookup (nothing hidden, non-TCP IP, unrelated
// port, non-IP family) show their result in the cycle right after acceptance
// and busy stays low, so one such word can enter every cycle.
// Words that touch the sender table send a scan word down the row of
// SENDER_SLOTS cells, one cell per cycle, then update the selected cell:
// busy is high while the scan word runs down the row, the result is shown
// once it leaves the last cell, and the next word can enter when busy falls
// again. The cell row length sets how long the scan lasts.
// The user must write the settings port (psel..prdata) only while busy is
// low; the block itself does not enforce it. Reset restores default settings,
// empties the sender table and clears busy and rsp_strobe.
// ----------------------------------------------------------------------------
module port_knock_sequence_filter import psf_pkg::*; #(
   parameter int SENDER_SLOTS = SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_l3_kind,
   input  logic                  req_is_tcp,
   input  logic [63:0]           req_src_addr_hi,
   input  logic [63:0]           req_src_addr_lo,
   input  logic [15:0]           req_dest_port,
   output logic                  rsp_strobe,
   output logic                  rsp_verdict,
   output logic                  rsp_send_reset,
   output logic                  rsp_table_full,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type   cfg;
   state_type state_ff, state_in;
   logic      go_ff, go_in;
   key_type   key_ff, key_in;
   logic [15:0] port_ff;
   logic      guard_ff;
   logic      strobe_ff, strobe_in;
   logic      verdict_ff, verdict_in;
   logic      sreset_ff, sreset_in;
   logic      full_ff, full_in;
   logic      accept;
   logic      is_ip, is_guard, is_knock, pass;
   logic [1:0] p;
   logic      advance;
   logic      done;
   cmd_type   cmd;

   logic      tok   [SENDER_SLOTS+1];
   carry_type carry [SENDER_SLOTS+1];

   psf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign tok[0]   = go_ff;
   assign carry[0] = '0;

   for (genvar i = 0; i < SENDER_SLOTS; i++) begin : g_cell
      psf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .tok_prev   (tok[i]),
         .carry_prev (carry[i]),
         .key        (key_ff),
         .cmd        (cmd),
         .tok_next   (tok[i+1]),
         .carry_next (carry[i+1])
      );
   end

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign done   = (state_ff == ST_SCAN) && tok[SENDER_SLOTS];

   always_comb begin
      is_ip    = (req_l3_kind == L3_IPV4) || (req_l3_kind == L3_IPV6);
      is_guard = ((cfg.guarded_count >= 2'd1) && (cfg.guarded_port_a == req_dest_port)) ||
                 ((cfg.guarded_count >= 2'd2) && (cfg.guarded_port_b == req_dest_port));
      is_knock = ((cfg.knock_length >= 2'd1) && (cfg.knock_first  == req_dest_port)) ||
                 ((cfg.knock_length >= 2'd2) && (cfg.knock_second == req_dest_port)) ||
                 ((cfg.knock_length >= 2'd3) && (cfg.knock_third  == req_dest_port));
      pass     = (cfg.guarded_count == 2'd0) || (is_ip && !req_is_tcp) ||
                 (!is_knock && !is_guard);

      key_in.v6 = (req_l3_kind == L3_IPV6);
      key_in.hi = key_in.v6 ? req_src_addr_hi : 64'd0;
      key_in.lo = key_in.v6 ? req_src_addr_lo : {32'd0, req_src_addr_lo[31:0]};

      p       = carry[SENDER_SLOTS].hit ? carry[SENDER_SLOTS].prog : 2'd0;
      advance = (p < cfg.knock_length) && (knock_at(cfg, p) == port_ff);

      cmd.en        = done && !guard_ff &&
                      (carry[SENDER_SLOTS].hit || carry[SENDER_SLOTS].free);
      cmd.alloc     = !carry[SENDER_SLOTS].hit;
      cmd.valid_new = advance;
      cmd.prog_new  = p + 2'd1;
   end

   always_comb begin
      state_in   = state_ff;
      go_in      = 1'b0;
      strobe_in  = 1'b0;
      verdict_in = verdict_ff;
      sreset_in  = sreset_ff;
      full_in    = full_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (pass) begin
                  strobe_in  = 1'b1;
                  verdict_in = 1'b0;
                  sreset_in  = 1'b0;
                  full_in    = 1'b0;
               end else if (!is_ip) begin
                  strobe_in  = 1'b1;
                  verdict_in = 1'b1;
                  sreset_in  = 1'b0;
                  full_in    = 1'b0;
               end else begin
                  go_in    = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (done) begin
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
               if (guard_ff) begin
                  verdict_in = !(carry[SENDER_SLOTS].hit &&
                                 (carry[SENDER_SLOTS].prog == cfg.knock_length));
                  sreset_in  = verdict_in;
                  full_in    = 1'b0;
               end else begin
                  verdict_in = 1'b1;
                  sreset_in  = 1'b1;
                  full_in    = !carry[SENDER_SLOTS].hit && !carry[SENDER_SLOTS].free;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         go_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         go_ff     <= go_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
      sreset_ff  <= sreset_in;
      full_ff    <= full_in;
      if (accept) begin
         key_ff   <= key_in;
         port_ff  <= req_dest_port;
         guard_ff <= is_guard;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_verdict    = verdict_ff;
   assign rsp_send_reset = sreset_ff;
   assign rsp_table_full = full_ff;

`include "port_knock_sequence_filter_assert.svh"

   `PSF_ASSERT_NEXT(a_accept_answered, clock, reset, accept, rsp_strobe || busy, "accepted word neither answered nor in progress")
   `PSF_ASSERT_NOW(a_accept_clean, clock, reset, rsp_strobe && !rsp_verdict, !rsp_send_reset && !rsp_table_full, "accepted packet carries reset or full flag")
   `PSF_ASSERT_NOW(a_scan_exit, clock, reset, tok[SENDER_SLOTS], state_ff == ST_SCAN, "scan word left the cell row outside a scan")

endmodule

// ===== tb/tb_port_knock_sequence_filter.sv =====
// ----------------------------------------------------------------------------
// Port knock sequence filter testbench
// Drives packet descriptors through the start/busy command port and checks
// every result word against a cycle-free model of the sender table. A short
// directed plan covers reset state, field extremes and the corner rules.
// Randomized phases follow, each with its own register setting and idle
// rate, built mostly from complete knock sequences plus noise, broken
// sequences and table floods.
// ----------------------------------------------------------------------------
module tb_port_knock_sequence_filter;
   import psf_pkg::*;

   localparam int SENDER_SLOTS = SLOTS_DEFAULT;
   localparam int POOL_SIZE = 24;
   localparam int FLOOD_SIZE = 18;

   localparam logic [1:0] L3_OTHER    = 2'd0;
   localparam logic [1:0] L3_RESERVED = 2'd3;

   typedef struct packed {
      logic verdict;
      logic send_reset;
      logic table_full;
   } verdict_type;

   localparam verdict_type VERDICT_ACCEPT     = 3'b000;
   localparam verdict_type VERDICT_DROP_RST   = 3'b110;
   localparam verdict_type VERDICT_DROP_QUIET = 3'b100;

   typedef enum logic {
      ROW_WORD,
      ROW_CSR
   } row_kind_type;

   typedef struct {
      row_kind_type  kind;
      reg_index_type csr_idx;
      logic [15:0]   csr_value;
      logic [1:0]    l3;
      logic          tcp;
      logic [63:0]   hi;
      logic [63:0]   lo;
      logic [15:0]   port;
      logic          fixed;
      verdict_type   res;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_l3_kind = '0;
   logic                  req_is_tcp = 1'b0;
   logic [63:0]           req_src_addr_hi = '0;
   logic [63:0]           req_src_addr_lo = '0;
   logic [15:0]           req_dest_port = '0;
   logic                  rsp_strobe;
   logic                  rsp_verdict;
   logic                  rsp_send_reset;
   logic                  rsp_table_full;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   logic                  word_fixed = 1'b0;
   verdict_type           word_fixed_res = VERDICT_ACCEPT;

   logic [15:0] cfg_knock [3];
   logic [1:0]  cfg_klen;
   logic [15:0] cfg_gport_a;
   logic [15:0] cfg_gport_b;
   logic [1:0]  cfg_gcount;

   logic [SENDER_SLOTS-1:0] slot_live;
   logic                    slot_v6   [SENDER_SLOTS];
   logic [63:0]             slot_hi   [SENDER_SLOTS];
   logic [63:0]             slot_lo   [SENDER_SLOTS];
   logic [1:0]              slot_prog [SENDER_SLOTS];

   verdict_type  pending_verdicts [$];
   plan_row_type directed_plan [$];
   int           mismatch_count = 0;
   int           words_sent = 0;
   int           gap_pct = 0;

   logic [1:0]  pool_kind [POOL_SIZE];
   logic [63:0] pool_hi   [POOL_SIZE];
   logic [63:0] pool_lo   [POOL_SIZE];

   port_knock_sequence_filter #(.SENDER_SLOTS(SENDER_SLOTS)) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_l3_kind(req_l3_kind),
      .req_is_tcp(req_is_tcp),
      .req_src_addr_hi(req_src_addr_hi),
      .req_src_addr_lo(req_src_addr_lo),
      .req_dest_port(req_dest_port),
      .rsp_strobe(rsp_strobe),
      .rsp_verdict(rsp_verdict),
      .rsp_send_reset(rsp_send_reset),
      .rsp_table_full(rsp_table_full),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #10 clock = ~clock;

   function automatic logic [15:0] seq_port(logic [1:0] i);
      case (i)
         2'd0:    return cfg_knock[0];
         2'd1:    return cfg_knock[1];
         default: return cfg_knock[2];
      endcase
   endfunction

   function automatic logic is_knock(logic [15:0] port);
      int i;
      for (i = 0; i < cfg_klen; i++)
         if (seq_port(i[1:0]) == port) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic is_hidden(logic [15:0] port);
      if (cfg_gcount >= 2'd1 && cfg_gport_a == port) return 1'b1;
      if (cfg_gcount >= 2'd2 && cfg_gport_b == port) return 1'b1;
      return 1'b0;
   endfunction

   function automatic int find_sender(logic v6, logic [63:0] hi, logic [63:0] lo);
      int i;
      for (i = 0; i < SENDER_SLOTS; i++)
         if (slot_live[i] && slot_v6[i] == v6 && slot_hi[i] == hi && slot_lo[i] == lo)
            return i;
      return -1;
   endfunction

   function automatic verdict_type judge_packet(logic [1:0] kind, logic tcp, logic [63:0] hi,
                                                logic [63:0] lo, logic [15:0] port);
      logic        ip;
      logic        v6;
      logic        hidden;
      logic        drop;
      logic        full;
      logic [1:0]  p;
      int          s;
      int          i;
      verdict_type res;
      ip = (kind == L3_IPV4) || (kind == L3_IPV6);
      v6 = (kind == L3_IPV6);
      hidden = is_hidden(port);
      res = VERDICT_ACCEPT;
      if (cfg_gcount == 2'd0 || (ip && !tcp) || (!is_knock(port) && !hidden)) return res;
      if (!v6) begin
         hi = '0;
         lo = {32'd0, lo[31:0]};
      end
      drop = 1'b1;
      full = 1'b0;
      if (hidden) begin
         if (ip) begin
            s = find_sender(v6, hi, lo);
            if (s >= 0 && slot_prog[s] == cfg_klen) drop = 1'b0;
         end
      end else if (ip) begin
         s = find_sender(v6, hi, lo);
         if (s < 0) begin
            for (i = 0; i < SENDER_SLOTS && s < 0; i++)
               if (!slot_live[i]) s = i;
            if (s < 0) begin
               full = 1'b1;
            end else begin
               slot_live[s] = 1'b1;
               slot_v6[s] = v6;
               slot_hi[s] = hi;
               slot_lo[s] = lo;
               slot_prog[s] = 2'd0;
            end
         end
         if (s >= 0) begin
            p = slot_prog[s];
            if (p < cfg_klen && seq_port(p) == port) slot_prog[s] = p + 2'd1;
            else slot_live[s] = 1'b0;
         end
      end
      if (drop) begin
         res.verdict = 1'b1;
         res.send_reset = ip;
         res.table_full = full;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      verdict_type pred;
      if (reset) begin
         pending_verdicts.delete();
         slot_live = '0;
         cfg_knock[0] = KNOCK_FIRST_RST;
         cfg_knock[1] = KNOCK_SECOND_RST;
         cfg_knock[2] = KNOCK_THIRD_RST;
         cfg_klen = KNOCK_LENGTH_RST;
         cfg_gport_a = GUARDED_PORT_RST;
         cfg_gport_b = GUARDED_PORT_RST;
         cfg_gcount = GUARDED_COUNT_RST;
      end else begin
         if (rsp_strobe) begin
            got = {rsp_verdict, rsp_send_reset, rsp_table_full};
            if (pending_verdicts.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result word at %0t: v=%b r=%b f=%b",
                           $time, got.verdict, got.send_reset, got.table_full);
               mismatch_count++;
            end else begin
               want = pending_verdicts.pop_front();
               if (got !== want) begin
                  if (mismatch_count < 10)
                     $display("mismatch at %0t: expected v=%b r=%b f=%b, got v=%b r=%b f=%b",
                              $time, want.verdict, want.send_reset, want.table_full,
                              got.verdict, got.send_reset, got.table_full);
                  mismatch_count++;
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[4:2]))
               REG_KNOCK_FIRST:    cfg_knock[0] = pwdata[15:0];
               REG_KNOCK_SECOND:   cfg_knock[1] = pwdata[15:0];
               REG_KNOCK_THIRD:    cfg_knock[2] = pwdata[15:0];
               REG_KNOCK_LENGTH:   cfg_klen = pwdata[1:0];
               REG_GUARDED_PORT_A: cfg_gport_a = pwdata[15:0];
               REG_GUARDED_PORT_B: cfg_gport_b = pwdata[15:0];
               REG_GUARDED_COUNT:  cfg_gcount = pwdata[1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            pred = judge_packet(req_l3_kind, req_is_tcp, req_src_addr_hi, req_src_addr_lo,
                                req_dest_port);
            pending_verdicts.push_back(word_fixed ? word_fixed_res : pred);
         end
      end
   end

   task automatic issue(logic [1:0] kind, logic tcp, logic [63:0] hi, logic [63:0] lo,
                        logic [15:0] port, logic fixed, verdict_type fixed_res);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_l3_kind <= kind;
      req_is_tcp <= tcp;
      req_src_addr_hi <= hi;
      req_src_addr_lo <= lo;
      req_dest_port <= port;
      word_fixed <= fixed;
      word_fixed_res <= fixed_res;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_verdicts.size() != 0 || busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [15:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= {16'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   function automatic void plan_word(logic [1:0] l3, logic tcp, logic [63:0] hi,
                                     logic [63:0] lo, logic [15:0] port, logic fixed,
                                     verdict_type res);
      plan_row_type r;
      r.kind = ROW_WORD;
      r.csr_idx = REG_KNOCK_FIRST;
      r.csr_value = '0;
      r.l3 = l3;
      r.tcp = tcp;
      r.hi = hi;
      r.lo = lo;
      r.port = port;
      r.fixed = fixed;
      r.res = res;
      directed_plan.push_back(r);
   endfunction

   function automatic void plan_csr(reg_index_type idx, logic [15:0] value);
      plan_row_type r;
      r.kind = ROW_CSR;
      r.csr_idx = idx;
      r.csr_value = value;
      r.l3 = L3_OTHER;
      r.tcp = 1'b0;
      r.hi = '0;
      r.lo = '0;
      r.port = '0;
      r.fixed = 1'b0;
      r.res = VERDICT_ACCEPT;
      directed_plan.push_back(r);
   endfunction

   function automatic logic [15:0] pick_hidden();
      if (cfg_gcount == 2'd0) return 16'($urandom_range(65535));
      if (cfg_gcount == 2'd1 || $urandom_range(1) == 0) return cfg_gport_a;
      return cfg_gport_b;
   endfunction

   task automatic send_from(int s, logic [15:0] port);
      issue(pool_kind[s], $urandom_range(19) != 0, pool_hi[s], pool_lo[s], port,
            1'b0, VERDICT_ACCEPT);
   endtask

   task automatic run_phase(int idle_pct, int items, logic [15:0] kf, logic [15:0] ks,
                            logic [15:0] kt, logic [1:0] klen, logic [15:0] ga,
                            logic [15:0] gb, logic [1:0] gc);
      int          target;
      int          pick;
      int          s;
      int          j;
      int          bad;
      logic [15:0] wrong;
      logic [1:0]  kind;
      drain();
      csr_write(REG_KNOCK_FIRST, kf);
      csr_write(REG_KNOCK_SECOND, ks);
      csr_write(REG_KNOCK_THIRD, kt);
      csr_write(REG_KNOCK_LENGTH, {14'd0, klen});
      csr_write(REG_GUARDED_PORT_A, ga);
      csr_write(REG_GUARDED_PORT_B, gb);
      csr_write(REG_GUARDED_COUNT, {14'd0, gc});
      gap_pct = idle_pct;
      for (s = 0; s < POOL_SIZE; s++) begin
         if (s % 6 == 5) begin
            pool_kind[s] = (pool_kind[s-1] == L3_IPV6) ? L3_IPV4 : L3_IPV6;
            pool_hi[s] = '0;
            pool_lo[s] = pool_lo[s-1];
         end else begin
            pool_kind[s] = $urandom_range(1) ? L3_IPV6 : L3_IPV4;
            pool_hi[s] = {$urandom, $urandom};
            pool_lo[s] = {$urandom, $urandom};
         end
      end
      target = words_sent + items;
      while (words_sent < target) begin
         pick = $urandom_range(99);
         s = $urandom_range(POOL_SIZE - 1);
         if (pick < 55) begin
            for (j = 0; j < cfg_klen; j++) send_from(s, seq_port(j[1:0]));
            for (j = $urandom_range(1, 2); j > 0; j--) send_from(s, pick_hidden());
         end else if (pick < 70) begin
            bad = $urandom_range(0, cfg_klen);
            wrong = $urandom_range(1) ? seq_port(2'($urandom_range(2)))
                                      : 16'($urandom_range(65535));
            for (j = 0; j < cfg_klen; j++)
               send_from(s, (j == bad) ? wrong : seq_port(j[1:0]));
            if ($urandom_range(1)) send_from(s, pick_hidden());
         end else if (pick < 90) begin
            case ($urandom_range(3))
               0:       wrong = seq_port(2'($urandom_range(2)));
               1:       wrong = pick_hidden();
               default: wrong = 16'($urandom_range(65535));
            endcase
            kind = 2'($urandom_range(3));
            if ($urandom_range(1))
               issue(kind, 1'($urandom_range(1)), {$urandom, $urandom},
                     {$urandom, $urandom}, wrong, 1'b0, VERDICT_ACCEPT);
            else
               issue($urandom_range(3) ? pool_kind[s] : kind, 1'($urandom_range(1)),
                     pool_hi[s], pool_lo[s], wrong, 1'b0, VERDICT_ACCEPT);
         end else if (pick < 95) begin
            for (j = 0; j < FLOOD_SIZE; j++)
               issue($urandom_range(1) ? L3_IPV6 : L3_IPV4, 1'b1, {$urandom, $urandom},
                     {$urandom, $urandom}, seq_port(2'd0), 1'b0, VERDICT_ACCEPT);
         end else begin
            drain();
         end
      end
   endtask

   initial begin
      #8_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int i;
      plan_row_type r;

      plan_word(L3_IPV4, 1'b1, 64'd0, 64'h0A00_0001, 16'd1500, 1'b1, VERDICT_ACCEPT);
      plan_word(L3_RESERVED, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                16'hFFFF, 1'b1, VERDICT_ACCEPT);
      plan_csr(REG_GUARDED_PORT_A, 16'd22);
      plan_csr(REG_GUARDED_PORT_B, 16'hFFFF);
      plan_csr(REG_GUARDED_COUNT, 16'd2);
      plan_word(L3_IPV4, 1'b1, 64'd0, 64'h0A00_0001, 16'd22, 1'b1, VERDICT_DROP_RST);
      plan_word(L3_IPV6, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                16'hFFFF, 1'b1, VERDICT_DROP_RST);
      plan_word(L3_OTHER, 1'b1, 64'd0, 64'd0, 16'd22, 1'b1, VERDICT_DROP_QUIET);
      plan_word(L3_RESERVED, 1'b0, 64'd0, 64'd0, 16'd1500, 1'b1, VERDICT_DROP_QUIET);
      plan_word(L3_IPV4, 1'b0, 64'd0, 64'd0, 16'd22, 1'b1, VERDICT_ACCEPT);
      plan_word(L3_IPV6, 1'b1, 64'd0, 64'd0, 16'd0, 1'b1, VERDICT_ACCEPT);
      // knock with junk above the IPv4 address, then use the clean address
      plan_word(L3_IPV4, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0A00_0001,
                16'd1500, 1'b0, VERDICT_ACCEPT);
      plan_word(L3_IPV4, 1'b1, 64'h1234_5678_9ABC_DEF0, 64'h0000_0000_0A00_0001,
                16'd2000, 1'b0, VERDICT_ACCEPT);
      plan_word(L3_IPV4, 1'b1, 64'd0, 64'hFFFF_0000_0A00_0001, 16'd2500, 1'b0,
                VERDICT_ACCEPT);
      plan_word(L3_IPV4, 1'b1, 64'd0, 64'h0A00_0001, 16'd22, 1'b0, VERDICT_ACCEPT);
      plan_word(L3_IPV6, 1'b1, 64'd0, 64'h0A00_0001, 16'd22, 1'b0, VERDICT_ACCEPT);
      plan_word(L3_IPV4, 1'b1, 64'd0, 64'h0A00_0001, 16'd2500, 1'b0, VERDICT_ACCEPT);
      plan_word(L3_IPV4, 1'b1, 64'd0, 64'h0A00_0001, 16'd22, 1'b0, VERDICT_ACCEPT);
      plan_word(L3_IPV6, 1'b1, 64'h2001_0DB8_0000_0001, 64'hFEED_0000_0000_0042,
                16'd1500, 1'b0, VERDICT_ACCEPT);
      plan_word(L3_IPV6, 1'b1, 64'h2001_0DB8_0000_0001, 64'hFEED_0000_0000_0042,
                16'd2500, 1'b0, VERDICT_ACCEPT);
      plan_word(L3_IPV6, 1'b1, 64'h2001_0DB8_0000_0001, 64'hFEED_0000_0000_0042,
                16'd1500, 1'b0, VERDICT_ACCEPT);
      plan_csr(REG_GUARDED_PORT_A, 16'd1500);
      plan_csr(REG_GUARDED_COUNT, 16'd3);
      plan_word(L3_IPV6, 1'b1, 64'h2001_0DB8_0000_0001, 64'hFEED_0000_0000_0042,
                16'd1500, 1'b0, VERDICT_ACCEPT);
      plan_word(L3_IPV6, 1'b1, 64'h2001_0DB8_0000_0001, 64'hFEED_0000_0000_0042,
                16'hFFFF, 1'b0, VERDICT_ACCEPT);
      plan_csr(REG_KNOCK_FIRST, 16'd0);
      plan_csr(REG_KNOCK_SECOND, 16'hFFFF);
      plan_csr(REG_KNOCK_THIRD, 16'd0);
      plan_csr(REG_KNOCK_LENGTH, 16'd1);
      plan_csr(REG_GUARDED_PORT_A, 16'd1234);
      plan_csr(REG_GUARDED_COUNT, 16'd1);
      plan_word(L3_IPV4, 1'b1, 64'd0, 64'hC0A8_0107, 16'd0, 1'b0, VERDICT_ACCEPT);
      plan_word(L3_IPV4, 1'b1, 64'd0, 64'hC0A8_0107, 16'd1234, 1'b0, VERDICT_ACCEPT);
      plan_csr(REG_KNOCK_LENGTH, 16'd0);
      plan_word(L3_IPV4, 1'b1, 64'd0, 64'hC0A8_0107, 16'd0, 1'b0, VERDICT_ACCEPT);
      plan_word(L3_IPV4, 1'b1, 64'd0, 64'hC0A8_0107, 16'd1234, 1'b0, VERDICT_ACCEPT);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      gap_pct = 22;
      for (i = 0; i < directed_plan.size(); i++) begin
         r = directed_plan[i];
         if (r.kind == ROW_CSR) begin
            drain();
            csr_write(r.csr_idx, r.csr_value);
         end else begin
            issue(r.l3, r.tcp, r.hi, r.lo, r.port, r.fixed, r.res);
         end
      end

      run_phase(0, 110, 16'd1500, 16'd2000, 16'd2500, 2'd3, 16'd22, 16'd443, 2'd2);
      run_phase(57, 110, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 2'd3, 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 2'd1);
      run_phase(22, 110, 16'd0, 16'hFFFF, 16'd0, 2'd2, 16'hFFFF, 16'd0, 2'd3);
      run_phase(0, 110, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 2'd1, 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 2'd2);
      run_phase(57, 110, 16'hFFFF, 16'd0, 16'hFFFF, 2'd3, 16'd1, 16'd2, 2'd2);
      run_phase(22, 110, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 2'd0, 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 2'd2);
      run_phase(57, 110, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 2'd3, 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 2'd0);
      run_phase(0, 110, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 2'd3, 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 2'd2);

      drain();
      repeat (SENDER_SLOTS + 4) @(posedge clock);
      if (mismatch_count == 0 && pending_verdicts.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
